// File: sv/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the infix-to-postfix converter
// Character codes, precedence and letter helpers, controller state and the
// command and status structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  typedef enum logic [1:0] {
    SRC_TOP,
    SRC_SYM,
    SRC_TERM
  } emit_src_e;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      set_ovf;
    logic      clear;
    logic      emit;
    emit_src_e src;
  } cmd_t;

  typedef struct packed {
    logic is_end;
    logic is_letter;
    logic close_paren;
    logic empty;
    logic full;
    logic prec;
    logic out_free;
  } status_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic has_prec(input logic [7:0] top, input logic [7:0] inc);
    if ((top == CH_LPAREN) || (inc == CH_LPAREN)) begin
      has_prec = 1'b0;
    end else if (inc == CH_RPAREN) begin
      has_prec = 1'b1;
    end else if ((top == CH_MUL) || (top == CH_DIV)) begin
      has_prec = 1'b1;
    end else if (((top == CH_ADD) || (top == CH_SUB)) &&
                 ((inc == CH_MUL) || (inc == CH_DIV))) begin
      has_prec = 1'b0;
    end else begin
      has_prec = 1'b1;
    end
  endfunction

endpackage

// File: sv/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl: controller for the infix-to-postfix converter
// Two-state machine that takes one item and then steers the datapath through
// pops, pushes and emissions until that item is fully handled.
// ----------------------------------------------------------------------------
module itp_ctrl
  import itp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.is_end) begin
          if (status_i.empty && status_i.out_free) begin
            state_d = ST_IDLE;
          end
        end else if (status_i.is_letter) begin
          if (status_i.out_free) begin
            state_d = ST_IDLE;
          end
        end else if (status_i.empty || !status_i.prec) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.src  = SRC_TOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        if (status_i.is_end) begin
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            if (!status_i.empty) begin
              cmd_o.pop = 1'b1;
              cmd_o.src = SRC_TOP;
            end else begin
              cmd_o.clear = 1'b1;
              cmd_o.src   = SRC_TERM;
            end
          end
        end else if (status_i.is_letter) begin
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.src  = SRC_SYM;
          end
        end else if (!status_i.empty && status_i.prec) begin
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.pop  = 1'b1;
            cmd_o.src  = SRC_TOP;
          end
        end else if (status_i.close_paren && !status_i.empty) begin
          cmd_o.pop = 1'b1;
        end else if (!status_i.full) begin
          cmd_o.push = 1'b1;
        end else begin
          cmd_o.set_ovf = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: sv/itp_dpath.sv
// ----------------------------------------------------------------------------
// itp_dpath: datapath for the infix-to-postfix converter
// Input item register, operator stack memory with a registered top entry,
// stack count, sticky overflow flag and the output register.
// ----------------------------------------------------------------------------
module itp_dpath
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       kind_i,
  input  logic [7:0] symbol_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_symbol_o,
  output logic       is_last_o,
  output logic       overflow_o,
  input  cmd_t       cmd_i,
  output status_t    status_o
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic          kind_q;
  logic [7:0]    sym_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_d;
  logic          ovf_q;
  logic          ovf_d;
  logic [7:0]    top_q;
  logic [7:0]    mem_q [STACK_DEPTH];
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          out_valid_q;
  logic          out_valid_d;
  logic [7:0]    out_sym_q;
  logic          out_last_q;
  logic          out_ovf_q;

  assign waddr = cnt_q[AW-1:0];
  assign raddr = cnt_q[AW-1:0] - AW'(2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      sym_q  <= symbol_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[waddr] <= sym_q;
      top_q        <= sym_q;
    end else if (cmd_i.pop) begin
      top_q <= mem_q[raddr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (cmd_i.push) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.src)
        SRC_TOP: begin
          out_sym_q  <= top_q;
          out_last_q <= 1'b0;
          out_ovf_q  <= 1'b0;
        end
        SRC_SYM: begin
          out_sym_q  <= sym_q;
          out_last_q <= 1'b0;
          out_ovf_q  <= 1'b0;
        end
        SRC_TERM: begin
          out_sym_q  <= CH_NUL;
          out_last_q <= 1'b1;
          out_ovf_q  <= ovf_q;
        end
        default: begin
          out_sym_q  <= CH_NUL;
          out_last_q <= 1'b0;
          out_ovf_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign is_last_o    = out_last_q;
  assign overflow_o   = out_ovf_q;

  assign status_o.is_end      = (kind_q == KIND_END);
  assign status_o.is_letter   = is_letter(sym_q);
  assign status_o.close_paren = (sym_q == CH_RPAREN);
  assign status_o.empty       = (cnt_q == '0);
  assign status_o.full        = (cnt_q == CW'(STACK_DEPTH));
  assign status_o.prec        = has_prec(top_q, sym_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// File: sv/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix converter
// Takes one infix character per transaction and returns postfix characters,
// with a terminator transaction that carries the overflow flag.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+------------------------------------
//   input   | in_valid_i, in_ready_o | kind_i, symbol_i
//   output  | out_valid_o,out_ready_i| out_symbol_o, is_last_o, overflow_o
//
// An item is loaded in the idle state and handled in the evaluate state, so
// a letter or a plain push passes through each state once. Each operator
// popped and emitted adds a further evaluate step, set by the single read
// port of the stack memory. An output stall holds the controller only while
// it has a result to emit. Reset empties the stack and clears the overflow
// flag at once; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       is_last_o,
  output logic       overflow_o
);

  cmd_t    cmd;
  status_t status;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .symbol_i     (symbol_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_symbol_o (out_symbol_o),
    .is_last_o    (is_last_o),
    .overflow_o   (overflow_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the infix-to-postfix converter
// Feeds directed and random infix character streams through the valid/ready
// input channel, predicts the postfix output with a local operator stack and
// compares every output transaction against the oldest expected one.
// ----------------------------------------------------------------------------
module testbench
  import itp_pkg::*;
;

  localparam int STACK_DEPTH = 32;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       ovf;
  } postfix_item_t;

  class postfix_predictor;
    logic [7:0]    op_stack [STACK_DEPTH];
    int unsigned   depth_used = 0;
    bit            ovf_seen = 1'b0;
    postfix_item_t postfix_q[$];
    int unsigned   mismatches = 0;

    function bit is_alpha(logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function bit outranks(logic [7:0] top, logic [7:0] inc);
      if ((top == CH_LPAREN) || (inc == CH_LPAREN)) return 1'b0;
      if (inc == CH_RPAREN) return 1'b1;
      if ((top == CH_MUL) || (top == CH_DIV)) return 1'b1;
      if (((top == CH_ADD) || (top == CH_SUB)) && ((inc == CH_MUL) || (inc == CH_DIV)))
        return 1'b0;
      return 1'b1;
    endfunction

    function void queue_result(logic [7:0] sym, logic last, logic ovf);
      postfix_item_t item;
      item.sym = sym;
      item.last = last;
      item.ovf = ovf;
      postfix_q.push_back(item);
    endfunction

    function void note_input(logic kind, logic [7:0] sym);
      if (kind == KIND_END) begin
        while (depth_used > 0) begin
          depth_used--;
          queue_result(op_stack[depth_used], 1'b0, 1'b0);
        end
        queue_result(CH_NUL, 1'b1, ovf_seen);
        ovf_seen = 1'b0;
      end else if (is_alpha(sym)) begin
        queue_result(sym, 1'b0, 1'b0);
      end else begin
        while ((depth_used > 0) && outranks(op_stack[depth_used - 1], sym)) begin
          depth_used--;
          queue_result(op_stack[depth_used], 1'b0, 1'b0);
        end
        if ((sym == CH_RPAREN) && (depth_used > 0)) begin
          depth_used--;
        end else if (depth_used < STACK_DEPTH) begin
          op_stack[depth_used] = sym;
          depth_used++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
    endfunction

    function void check_output(logic [7:0] sym, logic last, logic ovf);
      postfix_item_t want;
      if (postfix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output: symbol %h last %b overflow %b", sym, last, ovf);
        return;
      end
      want = postfix_q.pop_front();
      if ((sym !== want.sym) || (last !== want.last) || (ovf !== want.ovf)) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                   want.sym, want.last, want.ovf, sym, last, ovf);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       kind_i = KIND_CHAR;
  logic [7:0] symbol_i = CH_NUL;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_symbol_o;
  logic       is_last_o;
  logic       overflow_o;

  postfix_predictor postfix = new;
  int unsigned      send_idle_pct = 26;
  int unsigned      recv_idle_pct = 78;
  int unsigned      random_items = 0;
  logic [7:0]       expr_q[$];

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_symbol_o(out_symbol_o),
    .is_last_o   (is_last_o),
    .overflow_o  (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 200000);
    $display("[infix_to_postfix_converter] ERROR");
    $finish;
  end

  function automatic logic [7:0] random_letter();
    if ($urandom_range(1) == 0) return 8'(8'h41 + $urandom_range(25));
    return 8'(8'h61 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic void add_operand(int nest);
    if ((nest > 0) && ($urandom_range(3) == 0)) begin
      expr_q.push_back(CH_LPAREN);
      add_expression(nest - 1);
      expr_q.push_back(CH_RPAREN);
    end else begin
      expr_q.push_back(random_letter());
    end
  endfunction

  function automatic void add_expression(int nest);
    int terms;
    terms = $urandom_range(3);
    add_operand(nest);
    repeat (terms) begin
      expr_q.push_back(random_operator());
      add_operand(nest);
    end
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    symbol_i <= sym;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    postfix.note_input(kind, sym);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_item(KIND_CHAR, text[i]);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (postfix.postfix_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_sequence(input bit force_deep);
    int pick;
    int spot;
    int levels;
    expr_q.delete();
    pick = $urandom_range(99);
    if (force_deep || (pick < 6)) begin
      levels = force_deep ? STACK_DEPTH + 1 : $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
      repeat (levels) expr_q.push_back(CH_LPAREN);
      add_expression(1);
      repeat ($urandom_range(3)) expr_q.push_back(CH_RPAREN);
    end else if (pick < 78) begin
      add_expression(3);
    end else if (pick < 90) begin
      add_expression(2);
      spot = $urandom_range(expr_q.size() - 1);
      expr_q[spot] = 8'($urandom_range(255));
      if ($urandom_range(1) == 0) expr_q.push_front(CH_RPAREN);
    end else begin
      repeat ($urandom_range(1, 8)) expr_q.push_back(8'($urandom_range(255)));
    end
    foreach (expr_q[i]) send_item(KIND_CHAR, expr_q[i]);
    send_item(KIND_END, 8'($urandom_range(255)));
    random_items += expr_q.size() + 1;
  endtask

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (out_valid_o && out_ready_i)
        postfix.check_output(out_symbol_o, is_last_o, overflow_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk_i);
    end
  end

  initial begin
    int phase;
    phase = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("a*b+c*d");
    send_item(KIND_END, 8'hFF);
    send_text("(A-Z)/z");
    send_item(KIND_END, CH_NUL);
    send_text(")-");
    send_item(KIND_END, 8'h55);
    send_text("@[{");
    send_item(KIND_CHAR, 8'h60);
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_END, 8'hAA);
    send_item(KIND_END, 8'h00);

    send_random_sequence(1'b1);
    while (random_items < RANDOM_ITEMS) begin
      if ((phase == 0) && (random_items >= RANDOM_ITEMS / 3)) begin
        wait_for_drain();
        phase = 1;
        send_idle_pct = 78;
        recv_idle_pct = 26;
      end else if ((phase == 1) && (random_items >= 2 * RANDOM_ITEMS / 3)) begin
        wait_for_drain();
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_sequence(1'b0);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if ((postfix.mismatches == 0) && (postfix.postfix_q.size() == 0)) begin
      $display("[infix_to_postfix_converter] OK");
    end else begin
      $display("[infix_to_postfix_converter] ERROR");
    end
    $finish;
  end

endmodule

// File: infix_to_postfix_converter.f
sv/itp_pkg.sv
sv/itp_ctrl.sv
sv/itp_dpath.sv
sv/infix_to_postfix_converter.sv
test/testbench.sv
